FILE: src/window_level_gray_stretch_core_assert.svh
// ----------------------------------------------------------------------------
// Window/level gray stretch: assertion macros
// Concurrent checks on clk with rst_n, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef WINDOW_LEVEL_GRAY_STRETCH_CORE_ASSERT_SVH
`define WINDOW_LEVEL_GRAY_STRETCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WLGS_ASSERT_IMPLY(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("wlgs: same-cycle check failed");
// next-cycle implication
`define WLGS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("wlgs: next-cycle check failed");
`else
`define WLGS_ASSERT_IMPLY(label, pre, post)
`define WLGS_ASSERT_NEXT(label, pre, post)
`endif

`endif

FILE: src/wlgs_pkg.sv
// ----------------------------------------------------------------------------
// Window/level gray stretch package
// Widths, register indexes and the request record of the divider pipeline.
// ----------------------------------------------------------------------------
package wlgs_pkg;

    localparam int PIXEL_BITS = 32;
    localparam int GRAY_BITS  = 8;
    localparam int NUM_BITS   = PIXEL_BITS + GRAY_BITS;

    localparam logic [GRAY_BITS-1:0] GRAY_MAX  = 8'd255;
    localparam logic [GRAY_BITS-1:0] GRAY_ZERO = 8'd0;

    // configuration register indexes
    localparam logic CFG_BOTTOM = 1'b0;
    localparam logic CFG_TOP    = 1'b1;

    typedef struct packed {
        logic                  clamp;      // result fixed by a window clamp
        logic [GRAY_BITS-1:0]  clamp_gray;
        logic                  inv;        // reversed window: output 255 - q
        logic [NUM_BITS-1:0]   rem;        // partial remainder (numerator)
        logic [PIXEL_BITS-1:0] den;        // window span
        logic [GRAY_BITS-1:0]  quot;
    } div_t;

endpackage

FILE: src/wlgs_div.sv
// ----------------------------------------------------------------------------
// Window/level gray stretch: quotient pipeline
// Restoring division, one quotient bit per register stage, MSB first.
// ----------------------------------------------------------------------------
module wlgs_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wlgs_pkg::div_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output wlgs_pkg::div_t out_data
);

    localparam int STAGES = wlgs_pkg::GRAY_BITS;
    localparam int NB     = wlgs_pkg::NUM_BITS;

    logic           valid_reg [STAGES];
    wlgs_pkg::div_t stage_reg [STAGES];
    wlgs_pkg::div_t stage_next [STAGES];
    logic           src_valid [STAGES];
    wlgs_pkg::div_t src_data  [STAGES];
    logic           adv [STAGES+1];

    assign adv[STAGES] = out_ready;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            localparam int BIT = STAGES - 1 - k;
            logic [NB-1:0] den_sh;
            logic          fits;

            if (k == 0) begin : g_first
                assign src_valid[k] = in_valid;
                assign src_data[k]  = in_data;
            end
            else begin : g_rest
                assign src_valid[k] = valid_reg[k-1];
                assign src_data[k]  = stage_reg[k-1];
            end

            // stage moves when empty or when its successor moves
            assign adv[k]  = !valid_reg[k] || adv[k+1];
            assign den_sh  = NB'(src_data[k].den) << BIT;
            assign fits    = src_data[k].rem >= den_sh;

            always_comb
            begin
                stage_next[k] = src_data[k];
                if (fits)
                begin
                    stage_next[k].rem = src_data[k].rem - den_sh;
                end
                stage_next[k].quot[BIT] = fits;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (adv[k])
                begin
                    valid_reg[k] <= src_valid[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[k] && src_valid[k])
                begin
                    stage_reg[k] <= stage_next[k];
                end
            end
        end
    endgenerate

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = stage_reg[STAGES-1];

endmodule

FILE: src/window_level_gray_stretch_core.sv
// ----------------------------------------------------------------------------
// Window/level gray stretch core
// Maps signed fixed-point pixels to 8-bit gray levels through a clamped window.
// ----------------------------------------------------------------------------
// Usage:
//   Pixel requests enter on pixel_valid/pixel_ready with pixel_value; gray
//   levels leave on gray_valid/gray_ready with gray_level, one per pixel and
//   in order. Load window_bottom (index 0) and window_top (index 1) through
//   cfg_en/cfg_index/cfg_data while no pixel is in flight; writes take effect
//   at once. Swap the two for a reversed (negative) image.
//   Throughput: one pixel per clock while gray_ready is high, set by the
//   twelve-stage pipeline below with one quotient bit resolved per stage.
//   Stages: input register, window compare and differences, numerator times
//   255, eight restoring-division stages, output register.
//   Reset: all stage valid bits clear, window_bottom = 0, window_top = 65535.
//   Stall: when gray_ready is low the output register holds; stages behind
//   it keep filling any bubbles, and pixel_ready drops only once every stage
//   holds a pixel. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "window_level_gray_stretch_core_assert.svh"

module window_level_gray_stretch_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_en,
    input  logic                                  cfg_index,
    input  logic [wlgs_pkg::PIXEL_BITS-1:0]       cfg_data,
    input  logic                                  pixel_valid,
    output logic                                  pixel_ready,
    input  logic signed [wlgs_pkg::PIXEL_BITS-1:0] pixel_value,
    output logic                                  gray_valid,
    input  logic                                  gray_ready,
    output logic [wlgs_pkg::GRAY_BITS-1:0]        gray_level
);

    localparam int PB = wlgs_pkg::PIXEL_BITS;
    localparam int NB = wlgs_pkg::NUM_BITS;

    // window registers
    logic signed [PB-1:0] bottom_reg;
    logic signed [PB-1:0] top_reg;

    // stage 0: captured pixel
    logic                 v0_reg;
    logic signed [PB-1:0] pix0_reg;
    // stage 1: clamp decision and differences
    logic                 v1_reg;
    wlgs_pkg::div_t       s1_reg;
    wlgs_pkg::div_t       s1_next;
    // stage 2: numerator scaled by 255
    logic                 v2_reg;
    wlgs_pkg::div_t       s2_reg;
    wlgs_pkg::div_t       s2_next;
    // divider handshake
    logic                 div_in_ready;
    logic                 div_out_valid;
    wlgs_pkg::div_t       div_out;
    // output register
    logic                                 gray_valid_reg;
    logic [wlgs_pkg::GRAY_BITS-1:0]       gray_reg;
    logic [wlgs_pkg::GRAY_BITS-1:0]       gray_next;

    logic adv0;
    logic adv1;
    logic adv2;
    logic adv_out;

    logic [PB-1:0] fwd_num;
    logic [PB-1:0] fwd_den;
    logic [PB-1:0] rev_num;
    logic [PB-1:0] rev_den;

    // ------------------------------------------------------------------
    // Configuration: plain register writes, no read-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_reg <= '0;
            top_reg    <= PB'(65535);
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                wlgs_pkg::CFG_BOTTOM: bottom_reg <= cfg_data;
                wlgs_pkg::CFG_TOP:    top_reg    <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Advance chain: a stage moves when empty or when the next one moves,
    // so bubbles collapse while the output is stalled.
    // ------------------------------------------------------------------
    assign adv_out     = !gray_valid_reg || gray_ready;
    assign adv2        = !v2_reg || div_in_ready;
    assign adv1        = !v1_reg || adv2;
    assign adv0        = !v0_reg || adv1;
    assign pixel_ready = adv0;

    // ------------------------------------------------------------------
    // Stage 0: capture the pixel request
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv0)
        begin
            v0_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0 && pixel_valid)
        begin
            pix0_reg <= pixel_value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: compare against the window, clamp, form the differences.
    // The true differences are non-negative and below 2^PB, so the
    // wrapped PB-bit subtraction is exact.
    // ------------------------------------------------------------------
    assign fwd_num = pix0_reg - bottom_reg;
    assign fwd_den = top_reg - bottom_reg;
    assign rev_num = pix0_reg - top_reg;
    assign rev_den = bottom_reg - top_reg;

    always_comb
    begin
        s1_next            = '0;
        s1_next.clamp_gray = wlgs_pkg::GRAY_ZERO;
        priority if (top_reg > bottom_reg)
        begin
            priority if (pix0_reg >= top_reg)
            begin
                s1_next.clamp      = 1'b1;
                s1_next.clamp_gray = wlgs_pkg::GRAY_MAX;
            end
            else if (pix0_reg <= bottom_reg)
            begin
                s1_next.clamp = 1'b1;
            end
            else
            begin
                s1_next.rem = NB'(fwd_num);
                s1_next.den = fwd_den;
            end
        end
        else if (top_reg < bottom_reg)
        begin
            s1_next.inv = 1'b1;
            priority if (pix0_reg <= top_reg)
            begin
                s1_next.clamp      = 1'b1;
                s1_next.clamp_gray = wlgs_pkg::GRAY_MAX;
            end
            else if (pix0_reg >= bottom_reg)
            begin
                s1_next.clamp = 1'b1;
            end
            else
            begin
                s1_next.rem = NB'(rev_num);
                s1_next.den = rev_den;
            end
        end
        else
        begin
            // equal window edges: everything is black
            s1_next.clamp = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv1)
        begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && v0_reg)
        begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: numerator = 255 * difference, as (d << 8) - d
    // ------------------------------------------------------------------
    always_comb
    begin
        s2_next     = s1_reg;
        s2_next.rem = (s1_reg.rem << wlgs_pkg::GRAY_BITS) - s1_reg.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3..10: eight-bit quotient, one bit per stage
    // ------------------------------------------------------------------
    wlgs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_ready  (div_in_ready),
        .in_data   (s2_reg),
        .out_valid (div_out_valid),
        .out_ready (adv_out),
        .out_data  (div_out)
    );

    // ------------------------------------------------------------------
    // Stage 11: pick clamp or quotient, mirror for a reversed window
    // ------------------------------------------------------------------
    always_comb
    begin
        priority if (div_out.clamp)
        begin
            gray_next = div_out.clamp_gray;
        end
        else if (div_out.inv)
        begin
            gray_next = wlgs_pkg::GRAY_MAX - div_out.quot;
        end
        else
        begin
            gray_next = div_out.quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            gray_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && div_out_valid)
        begin
            gray_reg <= gray_next;
        end
    end

    assign gray_valid = gray_valid_reg;
    assign gray_level = gray_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // an unclamped pixel never divides by a zero span
    `WLGS_ASSERT_IMPLY(a_span_nonzero, v1_reg && !s1_reg.clamp, s1_reg.den != '0)
    // strictly inside the window the quotient stays below 255
    `WLGS_ASSERT_IMPLY(a_quot_range, div_out_valid && !div_out.clamp,
                       div_out.quot != wlgs_pkg::GRAY_MAX)
    // division leaves a remainder below the span
    `WLGS_ASSERT_IMPLY(a_rem_below_den, div_out_valid && !div_out.clamp,
                       div_out.rem < NB'(div_out.den))
    // intake stalls only when the output is blocked
    `WLGS_ASSERT_IMPLY(a_ready_stall, !pixel_ready, gray_valid && !gray_ready)
    // a pixel leaving stage 0 lands in stage 1
    `WLGS_ASSERT_NEXT(a_stage0_moves, v0_reg && adv1, v1_reg)

endmodule

FILE: sim/window_level_gray_stretch_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window/level gray stretch core testbench
// Feeds pixel requests through a series of window settings (reset, full range,
// reversed, equal, narrow, random) and checks every gray level in order against
// a listed level or a local integer model of the clamped linear stretch.
// ----------------------------------------------------------------------------
module window_level_gray_stretch_core_tb;

    localparam int PB             = wlgs_pkg::PIXEL_BITS;
    localparam int GB             = wlgs_pkg::GRAY_BITS;
    localparam int CLK_HALF       = 2;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int PIPE_LATENCY   = 11;
    localparam int IDLE_PCT       = 12;
    localparam int HOLD_CYCLES    = 60;
    localparam int RAND_PHASES    = 9;
    localparam int ITEMS_PER_PH   = 200;
    localparam int NO_GRAY        = -1;   // row is checked by the model only
    localparam int DIR_ROWS       = 23;

    localparam logic signed [PB-1:0] PIX_MIN = 32'sh8000_0000;
    localparam logic signed [PB-1:0] PIX_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        WIN_RESET,
        WIN_FULL,
        WIN_FULL_REV,
        WIN_EQUAL,
        WIN_NARROW,
        WIN_RANDOM,
        WIN_RANDOM_REV
    } window_kind_t;

    typedef struct packed {
        logic signed [PB-1:0] bottom;
        logic signed [PB-1:0] top;
        logic signed [PB-1:0] pixel;
        int                   gray;
    } dir_row_t;

    // DUT ports
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_en;
    logic                  cfg_index;
    logic [PB-1:0]         cfg_data;
    logic                  pixel_valid;
    logic                  pixel_ready;
    logic signed [PB-1:0]  pixel_value;
    logic                  gray_valid;
    logic                  gray_ready;
    logic [GB-1:0]         gray_level;

    // model copy of the window registers
    logic signed [PB-1:0]  win_bottom;
    logic signed [PB-1:0]  win_top;

    // gray levels still owed by the block, oldest first
    logic [GB-1:0]         gray_expect_q [$];

    bit  idle_on;     // random idling on both sides
    bit  hold_req;    // ask the receiver for one long hold-off
    int  errors;
    int  pixels_sent;
    int  grays_checked;
    int  window_writes;
    int  cycle_count;

    // Directed rows: extremes, clamps, equal and reversed windows. Windows
    // change only between rows where the row says so; the first rows run on
    // the reset window.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{32'sd0, 32'sd65535, 32'sd0,        int'(wlgs_pkg::GRAY_ZERO)},
        '{32'sd0, 32'sd65535, 32'sd65535,    int'(wlgs_pkg::GRAY_MAX)},
        '{32'sd0, 32'sd65535, -32'sd1,       int'(wlgs_pkg::GRAY_ZERO)},
        '{32'sd0, 32'sd65535, PIX_MIN,       int'(wlgs_pkg::GRAY_ZERO)},
        '{32'sd0, 32'sd65535, PIX_MAX,       int'(wlgs_pkg::GRAY_MAX)},
        '{32'sd0, 32'sd65535, 32'sd32767,    NO_GRAY},
        '{32'sd0, 32'sd65535, 32'sd1,        NO_GRAY},
        // equal registers: always black
        '{32'sd5, 32'sd5, 32'sd5,            int'(wlgs_pkg::GRAY_ZERO)},
        '{32'sd5, 32'sd5, PIX_MAX,           int'(wlgs_pkg::GRAY_ZERO)},
        '{32'sd5, 32'sd5, PIX_MIN,           int'(wlgs_pkg::GRAY_ZERO)},
        // widest window: span of 2^32 - 1
        '{PIX_MIN, PIX_MAX, PIX_MIN,         int'(wlgs_pkg::GRAY_ZERO)},
        '{PIX_MIN, PIX_MAX, PIX_MAX,         int'(wlgs_pkg::GRAY_MAX)},
        '{PIX_MIN, PIX_MAX, 32'sd0,          NO_GRAY},
        '{PIX_MIN, PIX_MAX, -32'sd1,         NO_GRAY},
        // widest reversed window
        '{PIX_MAX, PIX_MIN, PIX_MAX,         int'(wlgs_pkg::GRAY_ZERO)},
        '{PIX_MAX, PIX_MIN, PIX_MIN,         int'(wlgs_pkg::GRAY_MAX)},
        '{PIX_MAX, PIX_MIN, 32'sd0,          NO_GRAY},
        // reversed window across zero
        '{32'sd100, -32'sd100, -32'sd100,    int'(wlgs_pkg::GRAY_MAX)},
        '{32'sd100, -32'sd100, 32'sd100,     int'(wlgs_pkg::GRAY_ZERO)},
        '{32'sd100, -32'sd100, 32'sd0,       NO_GRAY},
        '{32'sd100, -32'sd100, 32'sd99,      NO_GRAY},
        '{32'sd100, -32'sd100, -32'sd99,     NO_GRAY},
        // narrowest window with an interior point
        '{-32'sd1, 32'sd1, 32'sd0,           NO_GRAY}
    };

    window_level_gray_stretch_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_en      (cfg_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_value (pixel_value),
        .gray_valid  (gray_valid),
        .gray_ready  (gray_ready),
        .gray_level  (gray_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Clamped linear stretch, worked in 64 bits so 255 times the widest
    // difference cannot overflow. Truncating division of non-negative values.
    function automatic logic [GB-1:0] stretch_gray(
        input logic signed [PB-1:0] pix,
        input logic signed [PB-1:0] bot,
        input logic signed [PB-1:0] top
    );
        longint v, b, t, g;
        v = pix;
        b = bot;
        t = top;
        if (t > b)
        begin
            if (v >= t)
                g = 255;
            else if (v <= b)
                g = 0;
            else
                g = (255 * (v - b)) / (t - b);
        end
        else if (t < b)
        begin
            // reversed window: mirror the clamps and the ramp
            if (v <= t)
                g = 255;
            else if (v >= b)
                g = 0;
            else
                g = 255 - (255 * (v - t)) / (b - t);
        end
        else
            g = 0;
        return g[GB-1:0];
    endfunction

    // Offer one pixel request, with a random gap first, and hold it until
    // taken. Returns right after the accepting edge.
    task automatic send_pixel(input logic signed [PB-1:0] pix, input int gray);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= pix;
        do
            @(posedge clk);
        while (!pixel_ready);
        if (gray >= 0)
            gray_expect_q.push_back(gray[GB-1:0]);
        else
            gray_expect_q.push_back(stretch_gray(pix, win_bottom, win_top));
        pixels_sent++;
    endtask

    // Drop valid and hold until every owed gray level has come back.
    // Ends on a falling edge.
    task automatic drain_pipe();
        @(negedge clk);
        pixel_valid <= 1'b0;
        while (gray_expect_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Load both window registers on back-to-back cycles. Call on a falling edge
    // with the pipe empty.
    task automatic write_window(
        input logic signed [PB-1:0] bot,
        input logic signed [PB-1:0] top
    );
        cfg_en    <= 1'b1;
        cfg_index <= wlgs_pkg::CFG_BOTTOM;
        cfg_data  <= bot;
        @(negedge clk);
        cfg_index <= wlgs_pkg::CFG_TOP;
        cfg_data  <= top;
        @(negedge clk);
        cfg_en    <= 1'b0;
        cfg_data  <= $urandom;
        win_bottom = bot;
        win_top    = top;
        window_writes++;
    endtask

    // Pick a pixel: mostly inside the window, often on its edges, sometimes
    // anywhere in the 32-bit range, at the range extremes or at zero.
    function automatic logic signed [PB-1:0] pick_pixel(
        input logic signed [PB-1:0] bot,
        input logic signed [PB-1:0] top
    );
        longint lo, hi, edge_v;
        longint unsigned span, offs;
        int sel;
        sel = $urandom_range(99);
        lo  = (bot < top) ? bot : top;
        hi  = (bot < top) ? top : bot;
        if (sel < 55)
        begin
            span = hi - lo;
            offs = {$urandom, $urandom} % (span + 1);
            return PB'(lo + longint'(offs));
        end
        else if (sel < 75)
        begin
            edge_v = ($urandom_range(1) != 0) ? lo : hi;
            return PB'(edge_v + $urandom_range(2) - 1);
        end
        else if (sel < 92)
            return $urandom;
        else
        begin
            case ($urandom_range(2))
                0:       return PIX_MIN;
                1:       return PIX_MAX;
                default: return '0;
            endcase
        end
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        gray_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                gray_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gray_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Scoreboard: compare each accepted gray level with the oldest one owed.
    always @(posedge clk)
    begin
        logic [GB-1:0] want;
        if (rst_n && gray_valid && gray_ready)
        begin
            if (gray_expect_q.size() == 0)
            begin
                $error("gray_level: unexpected result %0d with none owed", gray_level);
                errors++;
            end
            else
            begin
                want = gray_expect_q.pop_front();
                if (gray_level !== want)
                begin
                    $error("gray_level mismatch: expected %0d, actual %0d", want, gray_level);
                    errors++;
                end
                grays_checked++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        window_kind_t kind;
        logic signed [PB-1:0] bot, top, tmp;
        int ph, n;

        rst_n       = 1'b0;
        cfg_en      = 1'b0;
        cfg_index   = wlgs_pkg::CFG_BOTTOM;
        cfg_data    = '0;
        pixel_valid = 1'b0;
        pixel_value = '0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        errors      = 0;
        pixels_sent = 0;
        grays_checked = 0;
        window_writes = 0;
        cycle_count = 0;
        win_bottom  = 32'sd0;
        win_top     = 32'sd65535;

        // hold reset, release on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows; reload the window only when a row moves it
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].bottom != win_bottom || dir_rows[i].top != win_top)
            begin
                drain_pipe();
                write_window(dir_rows[i].bottom, dir_rows[i].top);
            end
            send_pixel(dir_rows[i].pixel, dir_rows[i].gray);
        end

        // random phases, one window setting each
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_pipe();
            kind = window_kind_t'(ph % 7);
            case (kind)
                WIN_RESET:
                begin
                    bot = 32'sd0;
                    top = 32'sd65535;
                end
                WIN_FULL:
                begin
                    bot = PIX_MIN;
                    top = PIX_MAX;
                end
                WIN_FULL_REV:
                begin
                    bot = PIX_MAX;
                    top = PIX_MIN;
                end
                WIN_EQUAL:
                begin
                    bot = $urandom;
                    top = bot;
                end
                WIN_NARROW:
                begin
                    bot = $urandom;
                    top = bot + $urandom_range(300, 1);
                end
                WIN_RANDOM, WIN_RANDOM_REV:
                begin
                    bot = $urandom;
                    top = $urandom;
                    // order the pair to match the wanted direction
                    if ((top < bot) == (kind == WIN_RANDOM))
                    begin
                        tmp = bot;
                        bot = top;
                        top = tmp;
                    end
                end
                default:
                begin
                    bot = 32'sd0;
                    top = 32'sd65535;
                end
            endcase
            write_window(bot, top);

            // a long stretch with no idling on either side
            idle_on = !(ph == 3 || ph == 4);

            for (n = 0; n < ITEMS_PER_PH; n++)
            begin
                // stall the output for a while; keep offering so the pipe fills
                if ((ph == 1 || ph == 6) && n == 50)
                    hold_req = 1'b1;
                // pause mid-phase until every result is back
                if (ph == 2 && n == 100)
                    drain_pipe();
                send_pixel(pick_pixel(bot, top), NO_GRAY);
            end
        end

        drain_pipe();
        repeat (PIPE_LATENCY + 8) @(posedge clk);

        if (gray_expect_q.size() != 0)
        begin
            $error("gray_level: %0d results never arrived", gray_expect_q.size());
            errors++;
        end

        $display("Run covered %0d pixel requests over %0d window loads", pixels_sent,
                 window_writes);
        $display("(normal, reversed, equal, narrow and full-range), %0d gray levels checked",
                 grays_checked);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
